@@ rtl/core/sgc_pkg.sv @@
// Shared types and constants for the scatter-gather chunker.
`default_nettype none
package sgc_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned LEN_W           = 31;
  localparam int unsigned ADDR_W          = 64;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned CNT_W           = 5;
  localparam int unsigned IDX_W           = 4;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_COPY  = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_TOO_LONG  = 2'd1;
  localparam logic [1:0] STS_NO_ENTRY  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] entry_address;
    logic [LEN_W-1:0]  entry_length;
    logic [KEY_W-1:0]  entry_key;
    logic [CNT_W-1:0]  entry_count;
    logic [LEN_W-1:0]  total_bytes;
    logic [LEN_W-1:0]  copy_length;
    logic [ADDR_W-1:0] buffer_base;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [KEY_W-1:0]  chunk_key;
    logic [ADDR_W-1:0] chunk_address;
    logic [LEN_W-1:0]  chunk_bytes;
    logic [ADDR_W-1:0] buffer_address;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] address;
  } table_entry_t;

  // Classified operation handed from the front end to the walker.
  typedef enum logic [1:0] {
    OP_ACK   = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2,
    OP_COPY  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  index;
    table_entry_t      entry;
    logic [CNT_W-1:0]  count;
    logic [LEN_W-1:0]  bytes;
    logic [ADDR_W-1:0] base;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/sgc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sgc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/sgc_front.sv @@
// Front end: accepts beats, classifies them and queues them for the walker.
`default_nettype none
module sgc_front #(
  parameter int unsigned MAX_ENTRIES = sgc_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sgc_pkg::in_item_t in_item,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  output sgc_pkg::cmd_t          cmd
);

  sgc_pkg::cmd_t  slot_r [2];
  sgc_pkg::cmd_t  cls;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push, pop;

  always_comb begin
    cls                = '0;
    cls.index          = in_item.entry_index;
    cls.entry.key      = in_item.entry_key;
    cls.entry.length   = in_item.entry_length;
    cls.entry.address  = in_item.entry_address;
    cls.base           = in_item.buffer_base;
    if (32'(in_item.entry_count) > MAX_ENTRIES) begin
      cls.count = sgc_pkg::CNT_W'(MAX_ENTRIES);
    end else begin
      cls.count = in_item.entry_count;
    end
    cls.bytes = in_item.copy_length;
    cls.op    = sgc_pkg::OP_ACK;
    unique case (in_item.action)
      sgc_pkg::ACT_LOAD: begin
        // A slot beyond the table is acknowledged but not written.
        if (32'(in_item.entry_index) < MAX_ENTRIES) begin
          cls.op = sgc_pkg::OP_LOAD;
        end
      end
      sgc_pkg::ACT_START: begin
        cls.op    = sgc_pkg::OP_START;
        cls.bytes = in_item.total_bytes;
      end
      sgc_pkg::ACT_COPY: begin
        if (in_item.copy_length != '0) begin
          cls.op = sgc_pkg::OP_COPY;
        end
      end
      default: cls.op = sgc_pkg::OP_ACK;
    endcase
  end

  assign in_ready  = (count_r != 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sgc_back.sv @@
// Back end: carries out queued operations and walks the table chunk by chunk.
`default_nettype none
module sgc_back #(
  parameter int unsigned MAX_ENTRIES = sgc_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire sgc_pkg::cmd_t         cmd,
  output logic                       tbl_we,
  output logic [AW-1:0]              tbl_waddr,
  output sgc_pkg::table_entry_t      tbl_wdata,
  output logic [AW-1:0]              tbl_raddr,
  input  wire sgc_pkg::table_entry_t tbl_rdata,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output sgc_pkg::out_item_t         out_item
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                valid_r, valid_nxt;
  logic [CW-1:0]                cursor_r, cursor_nxt;
  logic [sgc_pkg::LEN_W-1:0]    offset_r, offset_nxt;
  logic [sgc_pkg::LEN_W-1:0]    remaining_r, remaining_nxt;
  logic [CW-1:0]                cur_r, cur_nxt;
  logic [sgc_pkg::LEN_W-1:0]    off_r, off_nxt;
  logic [sgc_pkg::LEN_W-1:0]    left_r, left_nxt;
  logic [sgc_pkg::LEN_W-1:0]    done_r, done_nxt;
  logic [sgc_pkg::LEN_W-1:0]    req_r, req_nxt;
  logic [sgc_pkg::ADDR_W-1:0]   base_r, base_nxt;
  logic                         out_valid_r, out_valid_nxt;
  sgc_pkg::out_item_t           out_item_r, out_item_nxt;

  logic                         emit_ok;
  logic                         in_list;
  logic [sgc_pkg::LEN_W-1:0]    elen, avail, bytes;
  logic [CW-1:0]                cur_step;

  assign emit_ok   = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == ST_IDLE) && emit_ok;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign tbl_we    = cmd_valid && cmd_ready && (cmd.op == sgc_pkg::OP_LOAD);
  assign tbl_waddr = AW'(cmd.index);
  assign tbl_wdata = cmd.entry;
  // The read address follows the next cursor so that the entry is ready when the cursor takes that value.
  assign tbl_raddr = AW'(cur_nxt);

  assign in_list  = (cur_r < valid_r);
  assign elen     = in_list ? tbl_rdata.length : '0;
  assign avail    = elen - off_r;
  assign bytes    = (avail > left_r) ? left_r : avail;
  assign cur_step = in_list ? cur_r + 1'b1 : cur_r;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    cursor_nxt    = cursor_r;
    offset_nxt    = offset_r;
    remaining_nxt = remaining_r;
    cur_nxt       = cur_r;
    off_nxt       = off_r;
    left_nxt      = left_r;
    done_nxt      = done_r;
    req_nxt       = req_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          out_item_nxt.status = sgc_pkg::STS_OK;
          out_item_nxt.last   = 1'b1;
          unique case (cmd.op)
            sgc_pkg::OP_START: begin
              valid_nxt     = CW'(cmd.count);
              remaining_nxt = cmd.bytes;
              cursor_nxt    = '0;
              offset_nxt    = '0;
            end
            sgc_pkg::OP_COPY: begin
              if (cmd.bytes > remaining_r) begin
                out_item_nxt.status = sgc_pkg::STS_TOO_LONG;
              end else begin
                out_valid_nxt = out_valid_r && !out_ready;
                out_item_nxt  = out_item_r;
                state_nxt     = ST_WALK;
                cur_nxt       = cursor_r;
                off_nxt       = offset_r;
                left_nxt      = cmd.bytes;
                done_nxt      = '0;
                req_nxt       = cmd.bytes;
                base_nxt      = cmd.base;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (off_r >= elen) begin
          // Current entry is used up or empty: step to the next one, or report no entry past the list.
          if (cur_step < valid_r) begin
            cur_nxt = cur_step;
            off_nxt = '0;
          end else if (emit_ok) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt        = '0;
            out_item_nxt.status = sgc_pkg::STS_NO_ENTRY;
            out_item_nxt.last   = 1'b1;
            cursor_nxt          = cur_step;
            cur_nxt             = cur_step;
            state_nxt           = ST_IDLE;
          end
        end else if (emit_ok) begin
          out_valid_nxt                = 1'b1;
          out_item_nxt.status          = sgc_pkg::STS_OK;
          out_item_nxt.chunk_key       = tbl_rdata.key;
          out_item_nxt.chunk_address   = tbl_rdata.address + sgc_pkg::ADDR_W'(off_r);
          out_item_nxt.chunk_bytes     = bytes;
          out_item_nxt.buffer_address  = base_r + sgc_pkg::ADDR_W'(done_r);
          out_item_nxt.last            = (bytes == left_r);
          off_nxt  = off_r + bytes;
          left_nxt = left_r - bytes;
          done_nxt = done_r + bytes;
          if (bytes == left_r) begin
            cursor_nxt    = cur_r;
            offset_nxt    = off_r + bytes;
            remaining_nxt = remaining_r - req_r;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cursor_r    <= '0;
      offset_r    <= '0;
      remaining_r <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cursor_r    <= cursor_nxt;
      offset_r    <= offset_nxt;
      remaining_r <= remaining_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    off_r      <= off_nxt;
    left_r     <= left_nxt;
    done_r     <= done_nxt;
    req_r      <= req_nxt;
    base_r     <= base_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/scatter_gather_chunker.sv @@
// Scatter-gather chunker: a two-beat command queue feeds a table walker.
// An acknowledgement passes a queue slot and the walker's output register; a copy's first
// chunk passes a queue slot, the walk state and the output register after any skipped entries.
// The walker takes one queued beat per cycle while idle with its output free; a copy then
// emits one chunk or skips one entry per cycle, holding chunks while the output is stalled.
// Reset clears the queue, cursor, offset and counts; table contents are undefined until loaded.
`default_nettype none
module scatter_gather_chunker #(
  parameter int unsigned MAX_ENTRIES = sgc_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sgc_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sgc_pkg::out_item_t      out_item
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic                  cmd_valid, cmd_ready;
  sgc_pkg::cmd_t         cmd;
  logic                  tbl_we;
  logic [AW-1:0]         tbl_waddr, tbl_raddr;
  sgc_pkg::table_entry_t tbl_wdata, tbl_rdata;

  sgc_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  sgc_ram #(
    .WIDTH ($bits(sgc_pkg::table_entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  sgc_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

@@ test/sgc_walk_tracker.sv @@
// Beat tracker for the scatter-gather chunker: predicts every result beat and checks it.
`timescale 1ns / 1ps
module sgc_walk_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sgc_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sgc_pkg::out_item_t out_item,
  output int                 faults,
  output int                 outstanding
);
  import sgc_pkg::*;

  localparam int SLOTS        = MAX_ENTRIES_DEF;
  localparam int REPORT_LIMIT = 10;

  logic [ADDR_W-1:0] slot_address [SLOTS];
  logic [LEN_W-1:0]  slot_length  [SLOTS];
  logic [KEY_W-1:0]  slot_key     [SLOTS];
  logic [CNT_W-1:0]  list_entries;
  logic [CNT_W-1:0]  cursor;
  logic [LEN_W-1:0]  entry_offset;
  logic [LEN_W-1:0]  bytes_left;
  out_item_t         due_chunks [$];

  function automatic out_item_t ack(input logic [1:0] status);
    out_item_t r;
    r        = '0;
    r.status = status;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic out_item_t make_chunk(input logic [KEY_W-1:0] key,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [LEN_W-1:0] bytes,
                                           input logic [ADDR_W-1:0] dest,
                                           input logic fin);
    out_item_t r;
    r.status         = STS_OK;
    r.chunk_key      = key;
    r.chunk_address  = addr;
    r.chunk_bytes    = bytes;
    r.buffer_address = dest;
    r.last           = fin;
    return r;
  endfunction

  // Applies one input beat to the tracked list state and queues the beats it must produce.
  task automatic walk_request(input in_item_t beat);
    logic [LEN_W-1:0]  want;
    logic [LEN_W-1:0]  left;
    logic [LEN_W-1:0]  off;
    logic [LEN_W-1:0]  span;
    logic [LEN_W-1:0]  seg;
    logic [CNT_W-1:0]  cur;
    logic [ADDR_W-1:0] moved;
    bit                stuck;
    case (beat.action)
      ACT_LOAD: begin
        slot_address[beat.entry_index] = beat.entry_address;
        slot_length[beat.entry_index]  = beat.entry_length;
        slot_key[beat.entry_index]     = beat.entry_key;
        due_chunks.push_back(ack(STS_OK));
      end
      ACT_START: begin
        list_entries = (beat.entry_count > SLOTS) ? CNT_W'(SLOTS) : beat.entry_count;
        bytes_left   = beat.total_bytes;
        cursor       = '0;
        entry_offset = '0;
        due_chunks.push_back(ack(STS_OK));
      end
      ACT_COPY: begin
        want = beat.copy_length;
        if (want == '0) begin
          due_chunks.push_back(ack(STS_OK));
        end else if (want > bytes_left) begin
          due_chunks.push_back(ack(STS_TOO_LONG));
        end else begin
          left  = want;
          off   = entry_offset;
          cur   = cursor;
          moved = '0;
          stuck = 1'b0;
          while (left != '0 && !stuck) begin
            span = (cur < list_entries) ? slot_length[cur[IDX_W-1:0]] : '0;
            if (off >= span) begin
              // An exhausted or empty entry is stepped over; stepping off the list ends
              // the request, though the cursor keeps the ground it has gained.
              if (cur < list_entries) cur = cur + 1'b1;
              off = '0;
              if (cur >= list_entries) begin
                cursor = cur;
                due_chunks.push_back(ack(STS_NO_ENTRY));
                stuck = 1'b1;
              end
            end else begin
              seg = span - off;
              if (seg > left) seg = left;
              due_chunks.push_back(make_chunk(slot_key[cur[IDX_W-1:0]],
                                              slot_address[cur[IDX_W-1:0]] + ADDR_W'(off),
                                              seg, beat.buffer_base + moved, seg == left));
              off   = off + seg;
              left  = left - seg;
              moved = moved + ADDR_W'(seg);
            end
          end
          if (!stuck) begin
            cursor       = cur;
            entry_offset = off;
            bytes_left   = bytes_left - want;
          end
        end
      end
      default: begin
        due_chunks.push_back(ack(STS_OK));
      end
    endcase
  endtask

  task automatic check_chunk(input out_item_t got);
    out_item_t want;
    if (due_chunks.size() == 0) begin
      faults++;
      if (faults <= REPORT_LIMIT)
        $display("tracker: unexpected beat at %0t: sts=%0d key=%h addr=%h bytes=%h dest=%h last=%b",
                 $time, got.status, got.chunk_key, got.chunk_address, got.chunk_bytes,
                 got.buffer_address, got.last);
    end else begin
      want = due_chunks.pop_front();
      if (got.status !== want.status || got.chunk_key !== want.chunk_key ||
          got.chunk_address !== want.chunk_address || got.chunk_bytes !== want.chunk_bytes ||
          got.buffer_address !== want.buffer_address || got.last !== want.last) begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("tracker: mismatch at %0t: expected sts=%0d key=%h addr=%h bytes=%h dest=%h last=%b",
                   $time, want.status, want.chunk_key, want.chunk_address, want.chunk_bytes,
                   want.buffer_address, want.last);
          $display("tracker:                      got sts=%0d key=%h addr=%h bytes=%h dest=%h last=%b",
                   got.status, got.chunk_key, got.chunk_address, got.chunk_bytes,
                   got.buffer_address, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      list_entries = '0;
      cursor       = '0;
      entry_offset = '0;
      bytes_left   = '0;
      due_chunks.delete();
    end else begin
      // The input is taken first, so a beat's predictions are queued before any check.
      if (in_valid && in_ready) walk_request(in_item);
      if (out_valid && out_ready) check_chunk(out_item);
    end
    outstanding = due_chunks.size();
  end

endmodule

@@ test/tb.sv @@
// Top-level bench for the scatter-gather chunker: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
  import sgc_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 5;
  localparam int SLOTS          = MAX_ENTRIES_DEF;
  localparam int TOTAL_BEATS    = 270;
  localparam int HOLD_AT_BEAT   = 120;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_AT_BEAT  = 200;
  localparam int TAIL_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [1:0]        ACT_UNDEFINED = 2'd3;
  localparam logic [LEN_W-1:0]  LEN_MAX       = '1;
  localparam logic [ADDR_W-1:0] ADDR_MAX      = '1;
  localparam logic [KEY_W-1:0]  KEY_MAX       = '1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  int           faults;
  int           outstanding;
  int           beats_sent   = 0;
  int           quiet_cycles = 0;
  bit           tx_steady    = 1'b0;
  bit [SLOTS-1:0] loaded     = '0;

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  scatter_gather_chunker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  sgc_walk_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .faults      (faults),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 85) return LEN_W'($urandom_range(1, 40));
    if (r < 95) return LEN_W'($urandom_range(41, 5000));
    return LEN_W'($urandom);
  endfunction

  // Copies may only walk entries that have been written since reset.
  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < SLOTS && loaded[n]) n++;
    return n;
  endfunction

  function automatic in_item_t random_beat();
    in_item_t b;
    b.action        = ACT_COPY;
    b.entry_index   = IDX_W'($urandom);
    b.entry_address = {$urandom, $urandom};
    b.entry_length  = LEN_W'($urandom);
    b.entry_key     = $urandom;
    b.entry_count   = CNT_W'($urandom);
    b.total_bytes   = LEN_W'($urandom);
    b.copy_length   = LEN_W'($urandom);
    b.buffer_base   = {$urandom, $urandom};
    return b;
  endfunction

  function automatic in_item_t load_beat(input logic [IDX_W-1:0] idx,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [LEN_W-1:0] len,
                                         input logic [KEY_W-1:0] key);
    in_item_t b;
    b               = random_beat();
    b.action        = ACT_LOAD;
    b.entry_index   = idx;
    b.entry_address = addr;
    b.entry_length  = len;
    b.entry_key     = key;
    return b;
  endfunction

  function automatic in_item_t start_beat(input logic [CNT_W-1:0] cnt,
                                          input logic [LEN_W-1:0] total);
    in_item_t b;
    b             = random_beat();
    b.action      = ACT_START;
    b.entry_count = cnt;
    b.total_bytes = total;
    return b;
  endfunction

  function automatic in_item_t copy_beat(input logic [LEN_W-1:0] len,
                                         input logic [ADDR_W-1:0] base);
    in_item_t b;
    b             = random_beat();
    b.action      = ACT_COPY;
    b.copy_length = len;
    b.buffer_base = base;
    return b;
  endfunction

  function automatic in_item_t noise_beat();
    in_item_t b;
    int       prefix;
    int       r;
    b = random_beat();
    r = $urandom_range(0, 19);
    if (r == 0) b.action = ACT_UNDEFINED;
    else if (r < 8) b.action = ACT_LOAD;
    else if (r < 12) b.action = ACT_START;
    else b.action = ACT_COPY;
    prefix = loaded_prefix();
    if (b.action == ACT_START)
      b.entry_count = (prefix < SLOTS) ? CNT_W'($urandom_range(0, prefix)) : CNT_W'($urandom);
    if (b.action == ACT_COPY && $urandom_range(0, 1) == 1)
      b.copy_length = LEN_W'($urandom_range(1, 100));
    return b;
  endfunction

  task automatic send_beat(input in_item_t beat);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    do @(posedge clk); while (!in_ready);
    if (beat.action == ACT_LOAD) loaded[beat.entry_index] = 1'b1;
    beats_sent++;
  endtask

  // Holds the input back until the block has returned every beat it owes.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // Loads a fresh list, starts it and carves the byte count into several copies.
  task automatic run_list(input int count);
    longint unsigned  sum;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] total;
    logic [LEN_W-1:0] left;
    logic [LEN_W-1:0] req;
    logic [CNT_W-1:0] cnt;
    int               copies;
    int               r;
    sum       = 0;
    tx_steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      len = pick_length();
      sum = sum + len;
      send_beat(load_beat(IDX_W'(i), {$urandom, $urandom}, len, KEY_W'($urandom)));
    end
    r = $urandom_range(0, 3);
    // Claiming more bytes than the entries hold lets the walk run off the end.
    if (r == 0) sum = sum + $urandom_range(1, 100);
    else if (r == 1) sum = sum / 2;
    total = (sum > LEN_MAX) ? LEN_MAX : LEN_W'(sum);
    cnt   = CNT_W'(count);
    if (count == SLOTS && $urandom_range(0, 1) == 1)
      cnt = CNT_W'($urandom_range(SLOTS + 1, 31));
    send_beat(start_beat(cnt, total));
    left   = total;
    copies = $urandom_range(2, 6);
    for (int c = 0; c < copies; c++) begin
      r = $urandom_range(0, 9);
      if (r == 0) req = '0;
      else if (r == 1 && left < LEN_MAX - 64) req = left + LEN_W'($urandom_range(1, 50));
      else if (left == '0) req = LEN_W'($urandom_range(1, 20));
      else if (c == copies - 1) req = left;
      else if (r < 6 && left > 64) req = LEN_W'($urandom_range(1, 64));
      else req = LEN_W'($urandom_range(1, left));
      if (req <= left) left = left - req;
      send_beat(copy_beat(req, {$urandom, $urandom}));
    end
  endtask

  initial begin : rx_pacing
    int stall_left;
    int cycle;
    bit steady;
    bit held;
    stall_left = 0;
    cycle      = 0;
    steady     = 1'b0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 256 == 0) steady = ($urandom_range(0, 3) == 0);
      // One long hold-off while the sender keeps offering beats, so the block backs up.
      if (!held && beats_sent >= HOLD_AT_BEAT) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int scenario;
    bit mid_drained;
    scenario    = 0;
    mid_drained = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(load_beat(IDX_W'(0), ADDR_MAX, LEN_W'(4), KEY_MAX));
    send_beat(load_beat(IDX_W'(1), '0, '0, '0));
    send_beat(load_beat(IDX_W'(2), {$urandom, $urandom}, LEN_W'(10), KEY_W'($urandom)));
    send_beat(load_beat(IDX_W'(3), '0, LEN_MAX, '0));
    send_beat(load_beat(IDX_W'(SLOTS - 1), {$urandom, $urandom}, LEN_MAX, KEY_W'($urandom)));
    // Nothing started yet: an empty copy is acknowledged, any other is too long.
    send_beat(copy_beat('0, {$urandom, $urandom}));
    send_beat(copy_beat(LEN_W'(1), {$urandom, $urandom}));
    begin
      in_item_t odd;
      odd        = random_beat();
      odd.action = ACT_UNDEFINED;
      send_beat(odd);
    end
    // Wrapping addresses, a skipped empty entry and the full byte range.
    send_beat(start_beat(CNT_W'(4), LEN_MAX));
    send_beat(copy_beat(LEN_W'(6), ADDR_MAX));
    send_beat(copy_beat(LEN_MAX, ADDR_MAX));
    send_beat(copy_beat(LEN_MAX - LEN_W'(6), {$urandom, $urandom}));
    send_beat(copy_beat(LEN_W'(1), {$urandom, $urandom}));
    send_beat(start_beat(CNT_W'(4), LEN_W'(100)));
    send_beat(copy_beat(LEN_W'(50), {$urandom, $urandom}));
    // Running out of entries part way through, then with the cursor already past the list.
    send_beat(start_beat(CNT_W'(2), LEN_W'(100)));
    send_beat(copy_beat(LEN_W'(20), {$urandom, $urandom}));
    send_beat(copy_beat(LEN_W'(1), {$urandom, $urandom}));
    send_beat(start_beat('0, LEN_W'(5)));
    send_beat(copy_beat(LEN_W'(3), {$urandom, $urandom}));
    // A copy ending exactly at an entry boundary, then one starting beyond it.
    send_beat(start_beat(CNT_W'(4), LEN_W'(40)));
    send_beat(copy_beat(LEN_W'(4), {$urandom, $urandom}));
    send_beat(copy_beat(LEN_W'(10), {$urandom, $urandom}));
    drain();

    while (beats_sent < TOTAL_BEATS) begin
      if ($urandom_range(0, 4) == 0) begin
        send_beat(noise_beat());
      end else begin
        run_list((scenario % 5 == 0) ? SLOTS : $urandom_range(1, 6));
        scenario++;
      end
      if (!mid_drained && beats_sent >= DRAIN_AT_BEAT) begin
        drain();
        mid_drained = 1'b1;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
